// File: src/tacf_pkg.sv
// ----------------------------------------------------------------------------
// tacf_pkg
// Shared types and constants for the texture address / cube face unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tacf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 32;
    localparam int MAX_DIM     = 4096;
    localparam int MAX_BPT     = 16;

    // divider geometry: |minor+major| < 2^33, scaled by 2^FRAC_BITS
    localparam int DEN_W   = COORD_W + 1;
    localparam int NUM_W   = DEN_W + FRAC_BITS;
    localparam int VAL_W   = NUM_W + 1;
    localparam int DIV_LAT = NUM_W + 1;

    localparam int NORM_W  = FRAC_BITS + 1;
    localparam int TEX_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int BPT_W   = 5;
    localparam int ADDR_W  = 28;
    localparam int FACE_W  = 3;
    localparam int MODE_W  = 3;

    localparam logic [NORM_W-1:0] UNIT = NORM_W'(1) << FRAC_BITS;

    // register indexes
    localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BPT        = 3'd2;
    localparam logic [2:0] REG_MODE_U     = 3'd3;
    localparam logic [2:0] REG_MODE_V     = 3'd4;
    localparam logic [2:0] REG_PRESENT    = 3'd5;

    // addressing modes
    localparam logic [MODE_W-1:0] MODE_WRAP        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BORDER      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIRROR_ONCE = 3'd4;

    // cube faces
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic                    use_div;
        logic                    neg;
        logic [NUM_W-1:0]        num;
        logic [DEN_W-1:0]        den;
        logic signed [VAL_W-1:0] pass_val;
    } div_req_t;

endpackage

`default_nettype wire

// File: src/tacf_div.sv
// ----------------------------------------------------------------------------
// tacf_div
// Pipelined restoring divider, one quotient bit per stage, floor rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module tacf_div (
    input  wire logic                             aclk,
    input  wire logic                             ce,
    input  wire tacf_pkg::div_req_t               req,
    output logic signed [tacf_pkg::VAL_W-1:0]     quot
);
    import tacf_pkg::*;

    logic [NUM_W-1:0]        nq_reg   [NUM_W];
    logic [DEN_W-1:0]        rem_reg  [NUM_W];
    logic [DEN_W-1:0]        den_reg  [NUM_W];
    logic                    use_reg  [NUM_W];
    logic                    neg_reg  [NUM_W];
    logic signed [VAL_W-1:0] pass_reg [NUM_W];

    logic [NUM_W-1:0]        nq_src   [NUM_W];
    logic [DEN_W-1:0]        rem_src  [NUM_W];
    logic [DEN_W-1:0]        den_src  [NUM_W];
    logic                    use_src  [NUM_W];
    logic                    neg_src  [NUM_W];
    logic signed [VAL_W-1:0] pass_src [NUM_W];

    logic signed [VAL_W-1:0] quot_reg;
    logic [NUM_W-1:0]        q_fin;
    logic [NUM_W:0]          q_up;

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++) begin : g_step
            logic [DEN_W:0]   trial;
            logic             ge;
            logic [DEN_W-1:0] rem_next;
            logic [NUM_W-1:0] nq_next;

            if (i == 0) begin : g_first
                assign nq_src[i]   = req.num;
                assign rem_src[i]  = '0;
                assign den_src[i]  = req.den;
                assign use_src[i]  = req.use_div;
                assign neg_src[i]  = req.neg;
                assign pass_src[i] = req.pass_val;
            end else begin : g_rest
                assign nq_src[i]   = nq_reg[i-1];
                assign rem_src[i]  = rem_reg[i-1];
                assign den_src[i]  = den_reg[i-1];
                assign use_src[i]  = use_reg[i-1];
                assign neg_src[i]  = neg_reg[i-1];
                assign pass_src[i] = pass_reg[i-1];
            end

            always_comb begin
                trial    = {rem_src[i], nq_src[i][NUM_W-1]};
                ge       = (trial >= {1'b0, den_src[i]});
                rem_next = ge ? DEN_W'(trial - {1'b0, den_src[i]}) : trial[DEN_W-1:0];
                nq_next  = {nq_src[i][NUM_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    nq_reg[i]   <= nq_next;
                    rem_reg[i]  <= rem_next;
                    den_reg[i]  <= den_src[i];
                    use_reg[i]  <= use_src[i];
                    neg_reg[i]  <= neg_src[i];
                    pass_reg[i] <= pass_src[i];
                end
            end
        end
    endgenerate

    // negative numerator: floor = -(q + (r != 0))
    always_comb begin
        q_fin = nq_reg[NUM_W-1];
        q_up  = {1'b0, q_fin} + (NUM_W+1)'(rem_reg[NUM_W-1] != '0);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (!use_reg[NUM_W-1]) begin
                quot_reg <= pass_reg[NUM_W-1];
            end else if (neg_reg[NUM_W-1]) begin
                quot_reg <= -$signed({1'b0, q_up[NUM_W-1:0]});
            end else begin
                quot_reg <= $signed({1'b0, q_fin});
            end
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: src/texture_address_cube_face_unit.sv
// ----------------------------------------------------------------------------
// texture_address_cube_face_unit
// Cube face select, per-axis addressing and texel address generation.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                         tuser
//  s_       in         coord_u, coord_v, coord_w                  func
//  m_       out        face, norm_s, norm_t, texel_x, texel_y,    default_white
//                      texel_address, zero pad
//  cfg_     in         write enable, index, data                  -
//
//  The 49-step cube divider makes up most of the pipeline.
//  One transaction accepted per cycle when the output side is ready.
//  aresetn is synchronous; it clears valid bits and the configuration registers.
//  A stall on m_tready freezes every stage at once; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_address_cube_face_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // coord_u, coord_v, coord_w
    input  wire logic [0:0]  s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // face, norm_s, norm_t, texel_x, texel_y, texel_address
    output logic [0:0]       m_tuser,   // default_white
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata
);
    import tacf_pkg::*;

    // configuration
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [BPT_W-1:0]  bpt_reg;
    logic [MODE_W-1:0] mode_u_reg, mode_v_reg;
    logic              present_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= SIZE_W'(1);
            height_reg  <= SIZE_W'(1);
            bpt_reg     <= BPT_W'(4);
            mode_u_reg  <= MODE_WRAP;
            mode_v_reg  <= MODE_WRAP;
            present_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TEX_WIDTH:  width_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_TEX_HEIGHT: height_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_BPT:        bpt_reg     <= cfg_wdata[BPT_W-1:0];
                REG_MODE_U:     mode_u_reg  <= cfg_wdata[MODE_W-1:0];
                REG_MODE_V:     mode_v_reg  <= cfg_wdata[MODE_W-1:0];
                REG_PRESENT:    present_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    function automatic logic [SIZE_W-1:0] lim_dim(logic [SIZE_W-1:0] v);
        if (v == '0) return SIZE_W'(1);
        if (v > SIZE_W'(MAX_DIM)) return SIZE_W'(MAX_DIM);
        return v;
    endfunction

    function automatic logic [BPT_W-1:0] lim_bpt(logic [BPT_W-1:0] v);
        if (v == '0) return BPT_W'(1);
        if (v > BPT_W'(MAX_BPT)) return BPT_W'(MAX_BPT);
        return v;
    endfunction

    function automatic logic [NORM_W-1:0] addr_map(logic signed [VAL_W-1:0] v,
                                                   logic [MODE_W-1:0] mode);
        logic [VAL_W-FRAC_BITS-1:0] hi;
        logic [FRAC_BITS-1:0]       d;
        logic [NORM_W-1:0]          refl;
        logic                       neg, at_one;
        hi     = v[VAL_W-1:FRAC_BITS];
        d      = v[FRAC_BITS-1:0];
        neg    = v[VAL_W-1];
        at_one = (hi == (VAL_W-FRAC_BITS)'(1)) && (d == '0);
        refl   = UNIT - {1'b0, d};
        if (hi == '0) return {1'b0, d};
        case (mode)
            MODE_WRAP:        return {1'b0, d};
            MODE_MIRROR:      return v[FRAC_BITS] ? refl : {1'b0, d};
            MODE_BORDER:      return (neg || !at_one) ? '0 : UNIT;
            MODE_MIRROR_ONCE: return (neg || !at_one) ? refl : UNIT;
            default:          return neg ? '0 : UNIT;
        endcase
    endfunction

    logic ce;
    logic out_valid_reg;
    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // stage A: input capture
    logic                      a_valid_reg, a_func_reg;
    logic signed [COORD_W-1:0] a_x_reg, a_y_reg, a_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_func_reg <= s_tuser[0];
            a_x_reg    <= s_tdata[31:0];
            a_y_reg    <= s_tdata[63:32];
            a_z_reg    <= s_tdata[95:64];
        end
    end

    // stage B: magnitudes
    logic signed [DEN_W-1:0] a_xe, a_ye, a_ze;
    logic                    b_valid_reg, b_func_reg;
    logic signed [DEN_W-1:0] b_x_reg, b_y_reg, b_z_reg;
    logic [DEN_W-1:0]        b_ax_reg, b_ay_reg, b_az_reg;

    assign a_xe = DEN_W'(a_x_reg);
    assign a_ye = DEN_W'(a_y_reg);
    assign a_ze = DEN_W'(a_z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_func_reg <= a_func_reg;
            b_x_reg    <= a_xe;
            b_y_reg    <= a_ye;
            b_z_reg    <= a_ze;
            b_ax_reg   <= a_xe[DEN_W-1] ? DEN_W'(-a_xe) : DEN_W'(a_xe);
            b_ay_reg   <= a_ye[DEN_W-1] ? DEN_W'(-a_ye) : DEN_W'(a_ye);
            b_az_reg   <= a_ze[DEN_W-1] ? DEN_W'(-a_ze) : DEN_W'(a_ze);
        end
    end

    // stage C: major axis and face
    logic                    sel_x, sel_y;
    logic signed [DEN_W-1:0] c_minor_s_next, c_minor_t_next;
    logic [DEN_W-1:0]        c_major_next;
    logic [FACE_W-1:0]       c_face_next;

    always_comb begin
        sel_x = (b_ax_reg > b_ay_reg) && (b_ax_reg > b_az_reg);
        sel_y = (b_ay_reg > b_ax_reg) && (b_ay_reg > b_az_reg);
        if (!b_func_reg) begin
            c_minor_s_next = b_x_reg;
            c_minor_t_next = b_y_reg;
            c_major_next   = '0;
            c_face_next    = FACE_POS_X;
        end else if (sel_x) begin
            c_minor_s_next = b_x_reg[DEN_W-1] ? DEN_W'(-b_z_reg) : b_z_reg;
            c_minor_t_next = b_y_reg;
            c_major_next   = b_ax_reg;
            c_face_next    = b_x_reg[DEN_W-1] ? FACE_NEG_X : FACE_POS_X;
        end else if (sel_y) begin
            c_minor_s_next = b_x_reg;
            c_minor_t_next = b_y_reg[DEN_W-1] ? DEN_W'(-b_z_reg) : b_z_reg;
            c_major_next   = b_ay_reg;
            c_face_next    = b_y_reg[DEN_W-1] ? FACE_NEG_Y : FACE_POS_Y;
        end else if (b_z_reg > 0) begin
            c_minor_s_next = DEN_W'(-b_x_reg);
            c_minor_t_next = b_y_reg;
            c_major_next   = b_az_reg;
            c_face_next    = FACE_POS_Z;
        end else begin
            c_minor_s_next = b_x_reg;
            c_minor_t_next = b_y_reg;
            c_major_next   = b_az_reg;
            c_face_next    = FACE_NEG_Z;
        end
    end

    logic                    c_valid_reg, c_func_reg;
    logic signed [DEN_W-1:0] c_minor_s_reg, c_minor_t_reg;
    logic [DEN_W-1:0]        c_major_reg;
    logic [FACE_W-1:0]       c_face_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_func_reg    <= b_func_reg;
            c_minor_s_reg <= c_minor_s_next;
            c_minor_t_reg <= c_minor_t_next;
            c_major_reg   <= c_major_next;
            c_face_reg    <= c_face_next;
        end
    end

    // divider requests: floor((minor + major) * 2^F / (2 * major)); zero major passes 0.5, 2D passes minor
    function automatic div_req_t make_req(logic signed [DEN_W-1:0] minor,
                                          logic [DEN_W-1:0] major, logic func);
        div_req_t              r;
        logic signed [DEN_W:0] m;
        logic [DEN_W:0]        mag;
        m          = (DEN_W+1)'(minor) + $signed({1'b0, major});
        mag        = m[DEN_W] ? (DEN_W+1)'(-m) : m;
        r.neg      = m[DEN_W];
        r.num      = {mag[DEN_W-1:0], {FRAC_BITS{1'b0}}};
        r.den      = {major[DEN_W-2:0], 1'b0};
        r.use_div  = func && (major != '0);
        r.pass_val = func ? $signed(VAL_W'(UNIT >> 1)) : VAL_W'(minor);
        return r;
    endfunction

    div_req_t                req_s, req_t;
    logic signed [VAL_W-1:0] quot_s, quot_t;

    assign req_s = make_req(c_minor_s_reg, c_major_reg, c_func_reg);
    assign req_t = make_req(c_minor_t_reg, c_major_reg, c_func_reg);

    tacf_div u_div_s (.aclk(aclk), .ce(ce), .req(req_s), .quot(quot_s));
    tacf_div u_div_t (.aclk(aclk), .ce(ce), .req(req_t), .quot(quot_t));

    // side band alongside the divider
    logic              dly_valid_reg [DIV_LAT];
    logic [FACE_W-1:0] dly_face_reg  [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) dly_valid_reg[k] <= 1'b0;
        end else if (ce) begin
            dly_valid_reg[0] <= c_valid_reg;
            for (int k = 1; k < DIV_LAT; k++) dly_valid_reg[k] <= dly_valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_face_reg[0] <= c_face_reg;
            for (int k = 1; k < DIV_LAT; k++) dly_face_reg[k] <= dly_face_reg[k-1];
        end
    end

    // stage D: addressing modes
    logic              d_valid_reg;
    logic [FACE_W-1:0] d_face_reg;
    logic [NORM_W-1:0] d_ns_reg, d_nt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= dly_valid_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_face_reg <= dly_face_reg[DIV_LAT-1];
            d_ns_reg   <= addr_map(quot_s, mode_u_reg);
            d_nt_reg   <= addr_map(quot_t, mode_v_reg);
        end
    end

    // stage E: texel indices
    logic [SIZE_W-1:0]        w_lim, h_lim;
    logic [BPT_W-1:0]         b_lim;
    logic [TEX_W+NORM_W-1:0]  prod_x, prod_y;

    assign w_lim  = lim_dim(width_reg);
    assign h_lim  = lim_dim(height_reg);
    assign b_lim  = lim_bpt(bpt_reg);
    assign prod_x = TEX_W'(w_lim - SIZE_W'(1)) * d_ns_reg;
    assign prod_y = TEX_W'(h_lim - SIZE_W'(1)) * d_nt_reg;

    logic              e_valid_reg;
    logic [FACE_W-1:0] e_face_reg;
    logic [NORM_W-1:0] e_ns_reg, e_nt_reg;
    logic [TEX_W-1:0]  e_tx_reg, e_ty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (ce) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_face_reg <= d_face_reg;
            e_ns_reg   <= d_ns_reg;
            e_nt_reg   <= d_nt_reg;
            e_tx_reg   <= prod_x[FRAC_BITS +: TEX_W];
            e_ty_reg   <= prod_y[FRAC_BITS +: TEX_W];
        end
    end

    // stage F: row offset
    logic                     f_valid_reg;
    logic [FACE_W-1:0]        f_face_reg;
    logic [NORM_W-1:0]        f_ns_reg, f_nt_reg;
    logic [TEX_W-1:0]         f_tx_reg, f_ty_reg;
    logic [TEX_W+SIZE_W-1:0]  f_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (ce) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_face_reg <= e_face_reg;
            f_ns_reg   <= e_ns_reg;
            f_nt_reg   <= e_nt_reg;
            f_tx_reg   <= e_tx_reg;
            f_ty_reg   <= e_ty_reg;
            f_row_reg  <= e_ty_reg * w_lim;
        end
    end

    // stage G: byte address, output register
    logic [TEX_W+SIZE_W-1:0]       lin;
    logic [TEX_W+SIZE_W+BPT_W-1:0] byte_off;
    logic [88:0]                   pack_next;

    assign lin       = f_row_reg + (TEX_W+SIZE_W)'(f_tx_reg);
    assign byte_off  = lin * b_lim;
    assign pack_next = {byte_off[ADDR_W-1:0], f_ty_reg, f_tx_reg,
                        f_nt_reg, f_ns_reg, f_face_reg};

    logic [95:0] out_data_reg;
    logic        out_white_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_white_reg <= !present_reg;
            out_data_reg  <= present_reg ? {7'b0, pack_next} : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_white_reg;

`ifndef SYNTHESIS
    a_white_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("default white result carries data");

    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= FACE_NEG_Z)
        else $error("face out of range");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:3] <= UNIT && m_tdata[36:20] <= UNIT)
        else $error("normalised coordinate above one");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(d_ns_reg) && $stable(dly_valid_reg[DIV_LAT-1]))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

// File: sim/tb_texture_address_cube_face_unit.sv
// ----------------------------------------------------------------------------
// tb_texture_address_cube_face_unit
// Drives 2D and cube coordinate sets through the stream port under several
// register settings and idling phases, and compares every output transaction
// field by field against a behavioural predictor of face select, addressing
// and texel address generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_texture_address_cube_face_unit;
    import tacf_pkg::*;

    localparam int LATENCY = 3 + 50 + 4;

    typedef struct packed {
        logic [2:0]  face;
        logic [16:0] ns;
        logic [16:0] nt;
        logic [11:0] tx;
        logic [11:0] ty;
        logic [27:0] addr;
        logic        white;
    } texel_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_wdata = '0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          n_errors = 0;
    texel_res_t  expected_q[$];

    // shadow registers
    logic [12:0] r_width = 13'd1;
    logic [12:0] r_height = 13'd1;
    logic [4:0]  r_bpt = 5'd4;
    logic [2:0]  r_mode_u = MODE_WRAP;
    logic [2:0]  r_mode_v = MODE_WRAP;
    logic        r_present = 1'b0;

    texture_address_cube_face_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("tb_texture_address_cube_face_unit: done, errors");
        $finish;
    end

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint cube_half(longint minor, longint major);
        if (major == 0) return 64'sd32768;
        return floor_quot((minor + major) * 65536, 2 * major);
    endfunction

    function automatic longint apply_mode(longint v, logic [2:0] mode);
        longint n, d;
        if (v >= 0 && v < 65536) return v;
        n = floor_quot(v, 65536);
        d = v - n * 65536;
        case (mode)
            MODE_WRAP:        return d;
            MODE_MIRROR:      return n[0] ? 65536 - d : d;
            MODE_BORDER:      return (v > 65536 || v < 0) ? 0 : v;
            MODE_MIRROR_ONCE: return (v > 65536 || v < 0) ? 65536 - d : v;
            default: begin
                if (v > 65536) return 65536;
                if (v < 0) return 0;
                return v;
            end
        endcase
    endfunction

    function automatic longint clip_size(longint v, longint hi);
        if (v == 0) return 1;
        return v > hi ? hi : v;
    endfunction

    function automatic texel_res_t predict_texel(logic func, logic [31:0] cu,
                                                 logic [31:0] cv, logic [31:0] cw);
        texel_res_t r;
        longint x, y, z, ax, ay, az, s, t, ns, nt, w, h, b, tx, ty, addr;
        r = '0;
        if (!r_present) begin
            r.white = 1'b1;
            return r;
        end
        x = longint'($signed(cu));
        y = longint'($signed(cv));
        z = longint'($signed(cw));
        if (func) begin
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            az = z < 0 ? -z : z;
            if (ax > ay && ax > az) begin
                t = cube_half(y, ax);
                if (x > 0) begin s = cube_half(z, ax);  r.face = FACE_POS_X; end
                else begin       s = cube_half(-z, ax); r.face = FACE_NEG_X; end
            end else if (ay > ax && ay > az) begin
                s = cube_half(x, ay);
                if (y > 0) begin t = cube_half(z, ay);  r.face = FACE_POS_Y; end
                else begin       t = cube_half(-z, ay); r.face = FACE_NEG_Y; end
            end else begin
                t = cube_half(y, az);
                if (z > 0) begin s = cube_half(-x, az); r.face = FACE_POS_Z; end
                else begin       s = cube_half(x, az);  r.face = FACE_NEG_Z; end
            end
        end else begin
            s = x;
            t = y;
        end
        ns = apply_mode(s, r_mode_u);
        nt = apply_mode(t, r_mode_v);
        w = clip_size(r_width, MAX_DIM);
        h = clip_size(r_height, MAX_DIM);
        b = clip_size(r_bpt, MAX_BPT);
        tx = ((w - 1) * ns) >>> 16;
        ty = ((h - 1) * nt) >>> 16;
        addr = (tx + ty * w) * b;
        r.ns = ns[16:0];
        r.nt = nt[16:0];
        r.tx = tx[11:0];
        r.ty = ty[11:0];
        r.addr = addr[27:0];
        return r;
    endfunction

    // receiver: random stall, compare against oldest expectation
    always @(posedge aclk) begin
        texel_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction");
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[2:0] !== e.face) begin
                    $error("face exp %0d got %0d", e.face, m_tdata[2:0]); n_errors++;
                end
                if (m_tdata[19:3] !== e.ns) begin
                    $error("norm_s exp %0d got %0d", e.ns, m_tdata[19:3]); n_errors++;
                end
                if (m_tdata[36:20] !== e.nt) begin
                    $error("norm_t exp %0d got %0d", e.nt, m_tdata[36:20]); n_errors++;
                end
                if (m_tdata[48:37] !== e.tx) begin
                    $error("texel_x exp %0d got %0d", e.tx, m_tdata[48:37]); n_errors++;
                end
                if (m_tdata[60:49] !== e.ty) begin
                    $error("texel_y exp %0d got %0d", e.ty, m_tdata[60:49]); n_errors++;
                end
                if (m_tdata[88:61] !== e.addr) begin
                    $error("texel_address exp %0d got %0d", e.addr, m_tdata[88:61]);
                    n_errors++;
                end
                if (m_tuser[0] !== e.white) begin
                    $error("default_white exp %0d got %0d", e.white, m_tuser[0]);
                    n_errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_TEX_WIDTH:  r_width = val;
            REG_TEX_HEIGHT: r_height = val;
            REG_BPT:        r_bpt = val[4:0];
            REG_MODE_U:     r_mode_u = val[2:0];
            REG_MODE_V:     r_mode_v = val[2:0];
            REG_PRESENT:    r_present = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [12:0] w, logic [12:0] h, logic [4:0] b,
                             logic [2:0] mu, logic [2:0] mv, logic p);
        wait_drained();
        write_reg(REG_TEX_WIDTH, w);
        write_reg(REG_TEX_HEIGHT, h);
        write_reg(REG_BPT, 13'(b));
        write_reg(REG_MODE_U, 13'(mu));
        write_reg(REG_MODE_V, 13'(mv));
        write_reg(REG_PRESENT, 13'(p));
        cfg_we <= 1'b0;
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_coord(logic func, logic [31:0] cu, logic [31:0] cv,
                              logic [31:0] cw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cw, cv, cu};
        s_tuser <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_texel(func, cu, cv, cw));
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
            2: return 32'($urandom_range(65536));
            default: return 32'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic test_directed();
        configure(13'd1, 13'd1, 5'd4, MODE_WRAP, MODE_WRAP, 1'b0);
        send_coord(1'b0, 32'h0001_0000, 32'h0, 32'h0);      // no texture bound
        end_burst();
        configure(13'd4096, 13'd4096, 5'd16, MODE_CLAMP, MODE_MIRROR, 1'b1);
        send_coord(1'b0, 32'h0, 32'h0, 32'h0);
        send_coord(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0);   // exactly 1.0
        send_coord(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_coord(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_coord(1'b0, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_coord(1'b1, 32'h0, 32'h0, 32'h0);                   // all zero: -z face
        send_coord(1'b1, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_coord(1'b1, 32'hFFFE_0000, 32'h0001_0000, 32'h0000_8000);
        send_coord(1'b1, 32'h0000_4000, 32'h0003_0000, 32'h0001_0000);
        send_coord(1'b1, 32'h0000_4000, 32'hFFFD_0000, 32'h0001_0000);
        send_coord(1'b1, 32'h0001_0000, 32'h0, 32'h0005_0000);
        send_coord(1'b1, 32'h0001_0000, 32'h0, 32'hFFFB_0000);
        send_coord(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0);   // x/y tie, minor > major
        send_coord(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_coord(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        end_burst();
        configure(13'd0, 13'd8191, 5'd0, MODE_BORDER, MODE_MIRROR_ONCE, 1'b1);
        send_coord(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_coord(1'b0, 32'h0001_8000, 32'hFFFF_8000, 32'h0);
        send_coord(1'b0, 32'hFFFF_8000, 32'h0002_4000, 32'h0);
        end_burst();
        configure(13'd3, 13'd5, 5'd31, 3'd7, 3'd5, 1'b1);         // unused modes act as clamp
        send_coord(1'b0, 32'h0003_0000, 32'hFFFF_0000, 32'h0);
        send_coord(1'b0, 32'h0000_C000, 32'h0001_0000, 32'h0);
        end_burst();
    endtask

    task automatic test_random_phase(int n_items, int idle_pct, int stall_pct);
        logic [2:0] mu, mv;
        mu = 3'($urandom_range(7));
        mv = 3'($urandom_range(7));
        configure(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 64)),
                  5'($urandom_range(1, 16)), mu, mv, ($urandom_range(9) != 0));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items)
            send_coord(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
        end_burst();
    endtask

    task automatic test_pause_until_drained();
        send_coord(1'b1, rand_coord(), rand_coord(), rand_coord());
        end_burst();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (3) send_coord(1'b0, rand_coord(), rand_coord(), rand_coord());
        end_burst();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        for (int i = 0; i < 4; i++) begin
            test_random_phase(35, 0, 0);
            test_random_phase(35, 57, 0);
            test_random_phase(35, 0, 57);
            test_random_phase(25, 29, 29);
        end
        test_pause_until_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (n_errors == 0) begin
            $display("tb_texture_address_cube_face_unit: done, clean");
        end else begin
            $display("tb_texture_address_cube_face_unit: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
